// ----- rtl/core/sha256_pkg.sv -----
package sha256_pkg;

    typedef struct packed {
        logic [31:0] message_word;
        logic        final_block;
    } in_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic        digest_last;
    } out_item_t;

    // One complete block handed from the front to the core.
    typedef struct packed {
        logic [15:0][31:0] words;
        logic              final_block;
    } block_t;

    localparam logic [7:0][31:0] INIT_HASH = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam logic [63:0][31:0] ROUND_K = {
        32'hc67178f2, 32'hbef9a3f7, 32'ha4506ceb, 32'h90befffa,
        32'h8cc70208, 32'h84c87814, 32'h78a5636f, 32'h748f82ee,
        32'h682e6ff3, 32'h5b9cca4f, 32'h4ed8aa4a, 32'h391c0cb3,
        32'h34b0bcb5, 32'h2748774c, 32'h1e376c08, 32'h19a4c116,
        32'h106aa070, 32'hf40e3585, 32'hd6990624, 32'hd192e819,
        32'hc76c51a3, 32'hc24b8b70, 32'ha81a664b, 32'ha2bfe8a1,
        32'h92722c85, 32'h81c2c92e, 32'h766a0abb, 32'h650a7354,
        32'h53380d13, 32'h4d2c6dfc, 32'h2e1b2138, 32'h27b70a85,
        32'h14292967, 32'h06ca6351, 32'hd5a79147, 32'hc6e00bf3,
        32'hbf597fc7, 32'hb00327c8, 32'ha831c66d, 32'h983e5152,
        32'h76f988da, 32'h5cb0a9dc, 32'h4a7484aa, 32'h2de92c6f,
        32'h240ca1cc, 32'h0fc19dc6, 32'hefbe4786, 32'he49b69c1,
        32'hc19bf174, 32'h9bdc06a7, 32'h80deb1fe, 32'h72be5d74,
        32'h550c7dc3, 32'h243185be, 32'h12835b01, 32'hd807aa98,
        32'hab1c5ed5, 32'h923f82a4, 32'h59f111f1, 32'h3956c25b,
        32'he9b5dba5, 32'hb5c0fbcf, 32'h71374491, 32'h428a2f98
    };

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        ror = (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ----- rtl/core/sha256_front.sv -----
module sha256_front
    import sha256_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     valid,
    output logic     stall,
    input  in_item_t data,
    output logic     blk_valid,
    input  logic     blk_stall,
    output block_t   blk
);

    logic [3:0]        word_position_reg;
    logic [3:0]        word_position_next;
    logic [14:0][31:0] collect_reg;
    logic              full_reg;
    logic              full_next;
    block_t            blk_reg;
    logic              take;

    // One block buffer: the next block collects while the core works.
    assign stall     = full_reg && (word_position_reg == 4'd15);
    assign take      = valid && !stall;
    assign blk_valid = full_reg;
    assign blk       = blk_reg;

    always_comb
    begin
        word_position_next = word_position_reg;
        full_next          = full_reg;
        if (full_reg && !blk_stall)
        begin
            full_next = 1'b0;
        end
        if (take)
        begin
            word_position_next = word_position_reg + 4'd1;
            if (word_position_reg == 4'd15)
            begin
                full_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_position_reg <= '0;
            full_reg          <= 1'b0;
        end
        else
        begin
            word_position_reg <= word_position_next;
            full_reg          <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            if (word_position_reg == 4'd15)
            begin
                blk_reg.words       <= {data.message_word, collect_reg};
                blk_reg.final_block <= data.final_block;
            end
            else
            begin
                collect_reg[word_position_reg] <= data.message_word;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        full_reg && blk_stall |=> full_reg)
        else $error("block buffer dropped");
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        stall |-> full_reg)
        else $error("stall without full buffer");
    a_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        take && word_position_reg == 4'd15 |=> full_reg && word_position_reg == 4'd0)
        else $error("block completion lost");
`endif

endmodule

// ----- rtl/core/sha256_core.sv -----
module sha256_core
    import sha256_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      blk_valid,
    output logic      blk_stall,
    input  block_t    blk,
    output logic      valid,
    input  logic      stall,
    output out_item_t data
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ROUND = 4'b0010,
        ST_ADD   = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [5:0]        round_index_reg;
    logic [2:0]        emit_idx_reg;
    logic [7:0][31:0]  chain_value_reg;
    logic [7:0][31:0]  working_vars_reg;
    logic [15:0][31:0] schedule_window_reg;
    logic              final_reg;
    logic              out_valid_reg;
    out_item_t         out_reg;

    logic [31:0] wt, s0, s1, x15, x2, e_s1, ch, t1, a_s0, maj, t2;
    logic        out_free;

    assign out_free  = !out_valid_reg || !stall;
    assign blk_stall = (state_reg != ST_IDLE);
    assign valid     = out_valid_reg;
    assign data      = out_reg;

    always_comb
    begin
        x15 = schedule_window_reg[1];
        x2  = schedule_window_reg[14];
        s0  = ror(x15, 7) ^ ror(x15, 18) ^ (x15 >> 3);
        s1  = ror(x2, 17) ^ ror(x2, 19) ^ (x2 >> 10);
        if (round_index_reg < 6'd16)
        begin
            wt = schedule_window_reg[0];
        end
        else
        begin
            wt = schedule_window_reg[0] + s0 + schedule_window_reg[9] + s1;
        end
        e_s1 = ror(working_vars_reg[4], 6) ^ ror(working_vars_reg[4], 11)
             ^ ror(working_vars_reg[4], 25);
        ch   = (working_vars_reg[4] & working_vars_reg[5])
             ^ (~working_vars_reg[4] & working_vars_reg[6]);
        t1   = working_vars_reg[7] + e_s1 + ch + ROUND_K[round_index_reg] + wt;
        a_s0 = ror(working_vars_reg[0], 2) ^ ror(working_vars_reg[0], 13)
             ^ ror(working_vars_reg[0], 22);
        maj  = (working_vars_reg[0] & working_vars_reg[1])
             ^ (working_vars_reg[0] & working_vars_reg[2])
             ^ (working_vars_reg[1] & working_vars_reg[2]);
        t2   = a_s0 + maj;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (blk_valid)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                if (round_index_reg == 6'd63)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                state_next = final_reg ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (out_free && emit_idx_reg == 3'd7)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            round_index_reg <= '0;
            emit_idx_reg    <= '0;
            chain_value_reg <= INIT_HASH;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && !stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    round_index_reg <= '0;
                    emit_idx_reg    <= '0;
                end
                ST_ROUND:
                begin
                    round_index_reg <= round_index_reg + 6'd1;
                end
                ST_ADD:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        chain_value_reg[i] <= chain_value_reg[i] + working_vars_reg[i];
                    end
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        emit_idx_reg  <= emit_idx_reg + 3'd1;
                        if (emit_idx_reg == 3'd7)
                        begin
                            chain_value_reg <= INIT_HASH;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && blk_valid)
        begin
            schedule_window_reg <= blk.words;
            final_reg           <= blk.final_block;
            working_vars_reg    <= chain_value_reg;
        end
        else if (state_reg == ST_ROUND)
        begin
            schedule_window_reg <= {wt, schedule_window_reg[15:1]};
            working_vars_reg    <= {working_vars_reg[6:4], working_vars_reg[3] + t1,
                                    working_vars_reg[2:0], t1 + t2};
        end
        if (state_reg == ST_EMIT && out_free)
        begin
            out_reg.digest_word <= chain_value_reg[emit_idx_reg];
            out_reg.digest_last <= (emit_idx_reg == 3'd7);
        end
    end

`ifndef SYNTHESIS
    a_round_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ROUND && round_index_reg == 6'd63 |=> state_reg == ST_ADD)
        else $error("round count broken");
    a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state not one-hot");
    a_last_end: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT && out_free && emit_idx_reg == 3'd7 |=> state_reg == ST_IDLE)
        else $error("emit did not finish");
`endif

endmodule

// ----- rtl/core/sha256_block_hash.sv -----
// SHA-256 over a pre-padded message streamed as 32-bit big-endian words.
// Input channel: in_valid / in_stall / in_data (message_word, final_block).
// Every sixteenth word closes a 512-bit block. final_block on that word
// makes the block emit the digest; elsewhere it is ignored.
// Output channel: out_valid / out_stall / out_data (digest_word, digest_last),
// eight transactions, H0 first, digest_last on the eighth.
// Each block passes through the compression core as load, 64 rounds at one
// per cycle and chain add. A one-block buffer in front lets the next block's
// 16 words load while the core runs; the input stalls only when that buffer
// holds a block and its 16th word arrives. Digest words leave one per cycle
// from an output register; a stalled receiver holds the core in its emit
// phase and, through the buffer, the input. Reset clears all control state
// and loads the initial hash values; a partly loaded block is discarded.
module sha256_block_hash
    import sha256_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    logic   blk_valid;
    logic   blk_stall;
    block_t blk;

    sha256_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid     (in_valid),
        .stall     (in_stall),
        .data      (in_data),
        .blk_valid (blk_valid),
        .blk_stall (blk_stall),
        .blk       (blk)
    );

    sha256_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .blk_valid (blk_valid),
        .blk_stall (blk_stall),
        .blk       (blk),
        .valid     (out_valid),
        .stall     (out_stall),
        .data      (out_data)
    );

endmodule

// ----- tb/sha256_checker.sv -----
module sha256_checker
    import sha256_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_stall,
    input  in_item_t  in_data,
    input  logic      out_valid,
    input  logic      out_stall,
    input  out_item_t out_data,
    output int        fail_count,
    output int        pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };
    localparam logic [31:0] KTAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    logic [31:0] hash_state [8];
    logic [31:0] block_words [16];
    logic [3:0]  word_pos;
    out_item_t   digest_q [$];

    function automatic logic [31:0] rotr(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress_block();
        logic [31:0] w [16];
        logic [31:0] v [8];
        logic [31:0] wt, x15, x2, s0, s1, t1, t2;
        w = block_words;
        v = hash_state;
        for (int t = 0; t < 64; t++)
        begin
            if (t < 16)
                wt = w[t];
            else
            begin
                x15 = w[(t - 15) & 15];
                x2 = w[(t - 2) & 15];
                s0 = rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3);
                s1 = rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10);
                wt = w[t & 15] + s0 + w[(t - 7) & 15] + s1;
                w[t & 15] = wt;
            end
            s1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
            t1 = v[7] + s1 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTAB[t] + wt;
            s0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
            t2 = s0 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            hash_state[i] = hash_state[i] + v[i];
    endtask

    task automatic absorb_word(in_item_t it);
        out_item_t d;
        block_words[word_pos] = it.message_word;
        if (word_pos != 4'd15)
        begin
            word_pos++;
            return;
        end
        word_pos = 0;
        compress_block();
        if (!it.final_block)
            return;
        for (int i = 0; i < 8; i++)
        begin
            d.digest_word = hash_state[i];
            d.digest_last = (i == 7);
            digest_q.push_back(d);
        end
        hash_state = IV;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t exp_d;
        if (!rst_n)
        begin
            hash_state = IV;
            word_pos = 0;
            digest_q.delete();
            fail_count = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (digest_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected digest transaction %h", out_data);
                end
                else
                begin
                    exp_d = digest_q.pop_front();
                    if (out_data.digest_word !== exp_d.digest_word ||
                        out_data.digest_last !== exp_d.digest_last)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("digest mismatch: expected %h/%b got %h/%b",
                                     exp_d.digest_word, exp_d.digest_last,
                                     out_data.digest_word, out_data.digest_last);
                    end
                end
            end
            if (in_valid && !in_stall)
                absorb_word(in_data);
        end
        pending = digest_q.size();
    end
endmodule

// ----- tb/testbench.sv -----
module testbench;
    import sha256_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic      clk = 0;
    logic      rst_n = 0;
    logic      in_valid = 0;
    logic      in_stall;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_stall = 0;
    out_item_t out_data;
    int        fail_count;
    int        pending;
    bit        stim_done = 0;
    int        hold_off = 0;
    int        rx_wait = 0;
    int        idle_cycles = 0;

    sha256_block_hash dut (.*);
    sha256_checker chk (.*);

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    task automatic send_word(logic [31:0] w, logic fin);
        int gap;
        gap = $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1;
        in_data <= '{message_word: w, final_block: fin};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_block(int mode, logic fin);
        logic [31:0] w;
        for (int i = 0; i < 16; i++)
        begin
            case (mode)
                0: w = 32'h0;
                1: w = 32'hffffffff;
                default: w = $urandom;
            endcase
            // stray final flag on a non-closing word must be ignored
            send_word(w, (i == 15) ? fin : logic'($urandom_range(0, 5) == 0));
        end
    endtask

    always @(posedge clk)
    begin
        int draw;
        draw = $urandom_range(0, 7);
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            out_stall <= 1;
        end
        else if (rx_wait > 0)
        begin
            rx_wait <= rx_wait - 1;
            out_stall <= 1;
        end
        else if (out_valid && !out_stall && draw != 0)
        begin
            rx_wait <= draw - 1;
            out_stall <= 1;
        end
        else
            out_stall <= 0;
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        send_block(0, 1);
        send_block(1, 0);
        send_block(2, 1);
        hold_off <= 300;
        for (int b = 0; b < 4; b++)
            send_block(2, logic'(b != 1));
        in_valid <= 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        stim_done <= 1;
    end

    initial
    begin
        wait (stim_done);
        @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
